FILE: rtl/sllm_pkg.sv
// Shared types, constants and controller commands of the linked list manager.
package sllm_pkg;

  localparam int unsigned SLOTS     = 256;
  localparam int unsigned DATA_BITS = 32;
  localparam int unsigned SLOT_W    = $clog2(SLOTS);

  localparam logic [SLOT_W-1:0] FREE_SLOT = '0;
  localparam logic [SLOT_W-1:0] HEAD_SLOT = SLOT_W'(SLOTS - 1);
  localparam logic [SLOT_W-1:0] LAST_FREE = SLOT_W'(SLOTS - 2);

  // Action codes of a request.
  localparam logic [2:0] ACT_INSERT = 3'd0;
  localparam logic [2:0] ACT_DELETE = 3'd1;
  localparam logic [2:0] ACT_GET    = 3'd2;
  localparam logic [2:0] ACT_LOCATE = 3'd3;
  localparam logic [2:0] ACT_PRED   = 3'd4;
  localparam logic [2:0] ACT_SUCC   = 3'd5;
  localparam logic [2:0] ACT_CLEAR  = 3'd6;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef struct packed {
    logic [2:0]         action;
    logic [7:0]         position;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic               status;
    logic signed [31:0] value_out;
    logic [7:0]         slot_found;
    logic [7:0]         list_length;
    logic               is_empty;
  } rsp_t;

  typedef enum logic [4:0] {
    CMD_NOP,
    CMD_INIT,
    CMD_ACCEPT,
    CMD_RD_K,
    CMD_WALK_STEP,
    CMD_INS_RDF,
    CMD_INS_TAKE,
    CMD_INS_LINK,
    CMD_INS_HOOK,
    CMD_DEL_J,
    CMD_DEL_UNLINK,
    CMD_DEL_FREE,
    CMD_OUT_ELEM,
    CMD_SRCH_START,
    CMD_SRCH_NEXT,
    CMD_LOC_HIT,
    CMD_SUCC_HIT,
    CMD_PRED_HIT,
    CMD_CLR_SPLICE,
    CMD_CLR_NONE,
    CMD_LOAD_OUT
  } cmd_e;

  typedef struct packed {
    logic [2:0] action;
    logic       init_last;
    logic       pos_ok_ins;
    logic       pos_ok;
    logic       free_empty;
    logic       head_empty;
    logic       rem_zero;
    logic       rem_one;
    logic       cur_zero;
    logic       match;
    logic       next_zero;
    logic       out_free;
  } dp_status_t;

endpackage

FILE: rtl/static_linked_list_manager_core.sv
// Top level of the cursor-array linked list manager.
// This block keeps a singly linked list in a fixed array of 256 slots: slot 0 heads the
// chain of free slots and slot 255 heads the list, so up to 254 elements fit. Each request
// carries one action (insert before a position, delete, get, locate, predecessor,
// successor or clear) and produces exactly one result with status, value, found slot,
// new length and an empty flag. Requests are handled one at a time, and the cost is set
// by the link chase through the link memory, one registered link read per cycle: insert,
// delete and get walk to the position, locate, predecessor and successor visit elements
// in turn until a match or the end, and clear walks the whole list. After reset the block
// builds the free chain in memory and holds in_stall_o high meanwhile. A finished result
// waits in an output register, so the next request can be accepted while that result is
// still stalled.
module static_linked_list_manager_core import sllm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_data_o
);

  cmd_e       cmd;
  dp_status_t dp_status;

  // The controller sequences each request; it sees the datapath only through status.
  sllm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (dp_status),
    .cmd_o      (cmd)
  );

  // The datapath holds the memories, the cursors and the result register.
  sllm_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_data_i   (in_data_i),
    .status_o    (dp_status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: rtl/sllm_datapath.sv
// Datapath: link and element memories, cursor registers and the result register.
module sllm_datapath import sllm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_e       cmd_i,
  input  req_t       in_data_i,
  output dp_status_t status_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output rsp_t       out_data_o
);

  logic [SLOT_W-1:0]    link_mem [SLOTS];
  logic [DATA_BITS-1:0] elem_mem [SLOTS];

  logic [2:0]           act_q, act_d;
  logic [7:0]           pos_q, pos_d;
  logic [DATA_BITS-1:0] key_q, key_d;
  logic [SLOT_W-1:0]    k_q, k_d, j_q, j_d, rem_q, rem_d;
  logic [SLOT_W-1:0]    raddr_q, raddr_d, free_q, free_d, head_q, head_d;
  logic [SLOT_W-1:0]    init_idx_q, init_idx_d;
  logic [7:0]           cnt_q, cnt_d, found_q, found_d;
  logic [DATA_BITS-1:0] cand_q, cand_d, vout_q, vout_d;
  logic                 stat_q, stat_d;
  logic                 out_valid_q, out_valid_d;
  rsp_t                 out_q, out_d;

  logic [SLOT_W-1:0]    link_rq, link_eff;
  logic [DATA_BITS-1:0] elem_rq;

  logic                 lw_en, mw_en, ew_en;
  logic [SLOT_W-1:0]    lw_addr, lw_data, mw_addr, mw_data, ew_addr;

  // Slot 0 and the head slot live in registers; the rest in memory.
  always_comb begin
    if (raddr_q == FREE_SLOT) begin
      link_eff = free_q;
    end else if (raddr_q == HEAD_SLOT) begin
      link_eff = head_q;
    end else begin
      link_eff = link_rq;
    end
  end

  always_comb begin
    act_d       = act_q;
    pos_d       = pos_q;
    key_d       = key_q;
    k_d         = k_q;
    j_d         = j_q;
    rem_d       = rem_q;
    raddr_d     = raddr_q;
    free_d      = free_q;
    head_d      = head_q;
    init_idx_d  = init_idx_q;
    cnt_d       = cnt_q;
    found_d     = found_q;
    cand_d      = cand_q;
    vout_d      = vout_q;
    stat_d      = stat_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    lw_en       = 1'b0;
    lw_addr     = k_q;
    lw_data     = j_q;
    mw_en       = 1'b0;
    mw_addr     = init_idx_q;
    mw_data     = j_q;
    ew_en       = 1'b0;
    ew_addr     = free_q;

    unique case (cmd_i)
      CMD_INIT: begin
        mw_en      = 1'b1;
        mw_addr    = init_idx_q;
        mw_data    = (init_idx_q == LAST_FREE) ? FREE_SLOT : init_idx_q + 1'b1;
        init_idx_d = init_idx_q + 1'b1;
      end
      CMD_ACCEPT: begin
        act_d   = in_data_i.action;
        pos_d   = in_data_i.position;
        key_d   = DATA_BITS'(in_data_i.value);
        k_d     = HEAD_SLOT;
        rem_d   = (in_data_i.action == ACT_GET) ? SLOT_W'(in_data_i.position)
                                                : SLOT_W'(in_data_i.position - 8'd1);
        stat_d  = STATUS_ERR;
        vout_d  = '0;
        found_d = '0;
      end
      CMD_RD_K: begin
        raddr_d = k_q;
      end
      CMD_WALK_STEP: begin
        k_d     = link_eff;
        rem_d   = rem_q - 1'b1;
        raddr_d = link_eff;
      end
      CMD_INS_RDF: begin
        raddr_d = free_q;
      end
      CMD_INS_TAKE: begin
        j_d     = free_q;
        free_d  = link_eff;
        ew_en   = 1'b1;
        ew_addr = free_q;
        raddr_d = k_q;
      end
      CMD_INS_LINK: begin
        lw_en   = 1'b1;
        lw_addr = j_q;
        lw_data = link_eff;
      end
      CMD_INS_HOOK: begin
        lw_en   = 1'b1;
        lw_addr = k_q;
        lw_data = j_q;
        cnt_d   = cnt_q + 8'd1;
        stat_d  = STATUS_OK;
      end
      CMD_DEL_J: begin
        j_d     = link_eff;
        raddr_d = link_eff;
      end
      CMD_DEL_UNLINK: begin
        lw_en   = 1'b1;
        lw_addr = k_q;
        lw_data = link_eff;
        vout_d  = elem_rq;
      end
      CMD_DEL_FREE: begin
        // The freed slot goes to the front of the free chain.
        mw_en   = 1'b1;
        mw_addr = j_q;
        mw_data = free_q;
        free_d  = j_q;
        cnt_d   = cnt_q - 8'd1;
        stat_d  = STATUS_OK;
      end
      CMD_OUT_ELEM: begin
        vout_d = elem_rq;
        stat_d = STATUS_OK;
      end
      CMD_SRCH_START: begin
        raddr_d = head_q;
      end
      CMD_SRCH_NEXT: begin
        cand_d  = elem_rq;
        raddr_d = link_eff;
      end
      CMD_LOC_HIT: begin
        found_d = 8'(raddr_q);
        stat_d  = STATUS_OK;
      end
      CMD_SUCC_HIT: begin
        raddr_d = link_eff;
      end
      CMD_PRED_HIT: begin
        vout_d = cand_q;
        stat_d = STATUS_OK;
      end
      CMD_CLR_SPLICE: begin
        // The current read address is the tail of the list.
        mw_en   = 1'b1;
        mw_addr = raddr_q;
        mw_data = free_q;
        free_d  = head_q;
        head_d  = FREE_SLOT;
        cnt_d   = '0;
        stat_d  = STATUS_OK;
      end
      CMD_CLR_NONE: begin
        cnt_d  = '0;
        stat_d = STATUS_OK;
      end
      CMD_LOAD_OUT: begin
        out_valid_d       = 1'b1;
        out_d.status      = stat_q;
        out_d.value_out   = 32'(signed'(vout_q));
        out_d.slot_found  = found_q;
        out_d.list_length = cnt_q;
        out_d.is_empty    = (cnt_q == 8'd0);
      end
      default: begin
      end
    endcase

    if (lw_en) begin
      if (lw_addr == FREE_SLOT) begin
        free_d = lw_data;
      end else if (lw_addr == HEAD_SLOT) begin
        head_d = lw_data;
      end else begin
        mw_en   = 1'b1;
        mw_addr = lw_addr;
        mw_data = lw_data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mw_en) begin
      link_mem[mw_addr] <= mw_data;
    end
    if (ew_en) begin
      elem_mem[ew_addr] <= key_q;
    end
    link_rq <= link_mem[raddr_d];
    elem_rq <= elem_mem[raddr_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raddr_q     <= '0;
      free_q      <= SLOT_W'(1);
      head_q      <= FREE_SLOT;
      init_idx_q  <= SLOT_W'(1);
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      raddr_q     <= raddr_d;
      free_q      <= free_d;
      head_q      <= head_d;
      init_idx_q  <= init_idx_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q   <= act_d;
    pos_q   <= pos_d;
    key_q   <= key_d;
    k_q     <= k_d;
    j_q     <= j_d;
    rem_q   <= rem_d;
    found_q <= found_d;
    cand_q  <= cand_d;
    vout_q  <= vout_d;
    stat_q  <= stat_d;
    out_q   <= out_d;
  end

  always_comb begin
    status_o.action     = act_q;
    status_o.init_last  = (init_idx_q == LAST_FREE);
    status_o.pos_ok_ins = (pos_q != 8'd0) && ({1'b0, pos_q} <= ({1'b0, cnt_q} + 9'd1));
    status_o.pos_ok     = (pos_q != 8'd0) && (pos_q <= cnt_q);
    status_o.free_empty = (free_q == FREE_SLOT);
    status_o.head_empty = (head_q == FREE_SLOT);
    status_o.rem_zero   = (rem_q == '0);
    status_o.rem_one    = (rem_q == SLOT_W'(1));
    status_o.cur_zero   = (raddr_q == FREE_SLOT);
    status_o.match      = (elem_rq == key_q);
    status_o.next_zero  = (link_eff == FREE_SLOT);
    status_o.out_free   = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: rtl/sllm_ctrl.sv
// Controller state machine that sequences every list operation.
module sllm_ctrl import sllm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  dp_status_t status_i,
  output cmd_e       cmd_o
);

  localparam logic [4:0] S_INIT       = 5'd0;
  localparam logic [4:0] S_IDLE       = 5'd1;
  localparam logic [4:0] S_DISP       = 5'd2;
  localparam logic [4:0] S_WALK_ISS   = 5'd3;
  localparam logic [4:0] S_WALK       = 5'd4;
  localparam logic [4:0] S_INS_RDF    = 5'd5;
  localparam logic [4:0] S_INS_TAKE   = 5'd6;
  localparam logic [4:0] S_INS_LINK   = 5'd7;
  localparam logic [4:0] S_INS_HOOK   = 5'd8;
  localparam logic [4:0] S_DEL_RDK    = 5'd9;
  localparam logic [4:0] S_DEL_J      = 5'd10;
  localparam logic [4:0] S_DEL_UNLINK = 5'd11;
  localparam logic [4:0] S_DEL_FREE   = 5'd12;
  localparam logic [4:0] S_GET_RDK    = 5'd13;
  localparam logic [4:0] S_GET_OUT    = 5'd14;
  localparam logic [4:0] S_SRCH_ST    = 5'd15;
  localparam logic [4:0] S_PRED_2     = 5'd16;
  localparam logic [4:0] S_SRCH       = 5'd17;
  localparam logic [4:0] S_SUCC_OUT   = 5'd18;
  localparam logic [4:0] S_CLR_ST     = 5'd19;
  localparam logic [4:0] S_CLR_WALK   = 5'd20;
  localparam logic [4:0] S_DONE       = 5'd21;

  logic [4:0] state_q, state_d;
  logic [4:0] after_walk;

  always_comb begin
    priority if (status_i.action == ACT_INSERT) begin
      after_walk = S_INS_RDF;
    end else if (status_i.action == ACT_DELETE) begin
      after_walk = S_DEL_RDK;
    end else begin
      after_walk = S_GET_RDK;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = CMD_NOP;
    unique case (state_q)
      S_INIT: begin
        cmd_o = CMD_INIT;
        if (status_i.init_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o   = CMD_ACCEPT;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        unique case (status_i.action)
          ACT_INSERT: begin
            if (status_i.pos_ok_ins && !status_i.free_empty) begin
              state_d = status_i.rem_zero ? S_INS_RDF : S_WALK_ISS;
            end else begin
              state_d = S_DONE;
            end
          end
          ACT_DELETE, ACT_GET: begin
            if (status_i.pos_ok) begin
              state_d = status_i.rem_zero ? after_walk : S_WALK_ISS;
            end else begin
              state_d = S_DONE;
            end
          end
          ACT_LOCATE, ACT_SUCC: begin
            state_d = S_SRCH_ST;
          end
          ACT_PRED: begin
            state_d = status_i.head_empty ? S_DONE : S_SRCH_ST;
          end
          ACT_CLEAR: begin
            if (status_i.head_empty) begin
              cmd_o   = CMD_CLR_NONE;
              state_d = S_DONE;
            end else begin
              state_d = S_CLR_ST;
            end
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_WALK_ISS: begin
        cmd_o   = CMD_RD_K;
        state_d = S_WALK;
      end
      S_WALK: begin
        cmd_o = CMD_WALK_STEP;
        if (status_i.rem_one) begin
          state_d = after_walk;
        end
      end
      S_INS_RDF: begin
        cmd_o   = CMD_INS_RDF;
        state_d = S_INS_TAKE;
      end
      S_INS_TAKE: begin
        cmd_o   = CMD_INS_TAKE;
        state_d = S_INS_LINK;
      end
      S_INS_LINK: begin
        cmd_o   = CMD_INS_LINK;
        state_d = S_INS_HOOK;
      end
      S_INS_HOOK: begin
        cmd_o   = CMD_INS_HOOK;
        state_d = S_DONE;
      end
      S_DEL_RDK: begin
        cmd_o   = CMD_RD_K;
        state_d = S_DEL_J;
      end
      S_DEL_J: begin
        cmd_o   = CMD_DEL_J;
        state_d = S_DEL_UNLINK;
      end
      S_DEL_UNLINK: begin
        cmd_o   = CMD_DEL_UNLINK;
        state_d = S_DEL_FREE;
      end
      S_DEL_FREE: begin
        cmd_o   = CMD_DEL_FREE;
        state_d = S_DONE;
      end
      S_GET_RDK: begin
        cmd_o   = CMD_RD_K;
        state_d = S_GET_OUT;
      end
      S_GET_OUT: begin
        cmd_o   = CMD_OUT_ELEM;
        state_d = S_DONE;
      end
      S_SRCH_ST: begin
        cmd_o   = CMD_SRCH_START;
        state_d = (status_i.action == ACT_PRED) ? S_PRED_2 : S_SRCH;
      end
      S_PRED_2: begin
        cmd_o   = CMD_SRCH_NEXT;
        state_d = S_SRCH;
      end
      S_SRCH: begin
        priority if (status_i.cur_zero) begin
          state_d = S_DONE;
        end else if (status_i.match) begin
          priority if (status_i.action == ACT_LOCATE) begin
            cmd_o   = CMD_LOC_HIT;
            state_d = S_DONE;
          end else if (status_i.action == ACT_PRED) begin
            cmd_o   = CMD_PRED_HIT;
            state_d = S_DONE;
          end else if (status_i.next_zero) begin
            state_d = S_DONE;
          end else begin
            cmd_o   = CMD_SUCC_HIT;
            state_d = S_SUCC_OUT;
          end
        end else begin
          cmd_o = CMD_SRCH_NEXT;
        end
      end
      S_SUCC_OUT: begin
        cmd_o   = CMD_OUT_ELEM;
        state_d = S_DONE;
      end
      S_CLR_ST: begin
        cmd_o   = CMD_SRCH_START;
        state_d = S_CLR_WALK;
      end
      S_CLR_WALK: begin
        if (status_i.next_zero) begin
          cmd_o   = CMD_CLR_SPLICE;
          state_d = S_DONE;
        end else begin
          cmd_o = CMD_SRCH_NEXT;
        end
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o   = CMD_LOAD_OUT;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

FILE: rtl/sllm_checker.sv
// Port-level checker for the linked list manager and its bind statement.
module sllm_checker import sllm_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input req_t in_data_i,
  input logic out_valid_o,
  input logic out_stall_i,
  input rsp_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or vanished");

  a_empty_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.is_empty == (out_data_o.list_length == 8'd0)))
    else $error("empty flag disagrees with length");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while another is in progress");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.slot_found != 8'd0) |-> out_data_o.status == STATUS_OK)
    else $error("found slot reported with error status");

endmodule

bind static_linked_list_manager_core sllm_checker u_sllm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

FILE: verif/tb_static_linked_list_manager_core.sv
// Testbench of the cursor-array linked list manager: directed table, then random requests.
`timescale 1ns / 1ps
module tb_static_linked_list_manager_core;
  import sllm_pkg::*;

  localparam int HALF_PERIOD  = 10;
  localparam int CYCLE_LIMIT  = 3000000;
  localparam int DIRECTED_N   = 22;
  localparam int RANDOM_N     = 1230;
  localparam int HOLD_CYCLES  = 3000;
  localparam int DRAIN_CYCLES = 600;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  req_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b1;
  rsp_t out_data_o;

  static_linked_list_manager_core dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o(out_data_o)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // Model of the list: link array, element array and count.
  logic [7:0]  nxt_mdl [256];
  logic [31:0] elem_mdl [256];
  int          count_mdl;

  rsp_t expected_rsps [$];
  int   mismatches = 0;
  int   cycle_count = 0;
  int   sent_count = 0;

  // Idling percentages of sender and receiver.
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  bit   recv_hold = 1'b0;
  bit   hold_request = 1'b0;

  // Directed table: request and, where obvious, the typed-in expected result.
  typedef struct {
    req_t r;
    bit   fixed;
    rsp_t e;
  } vec_t;
  vec_t dir_tab [DIRECTED_N];
  vec_t pending_fixed [$];

  function automatic rsp_t mk_rsp(logic st, logic [31:0] v, logic [7:0] s, logic [7:0] n);
    rsp_t q;
    q.status = st;
    q.value_out = v;
    q.slot_found = s;
    q.list_length = n;
    q.is_empty = (n == 0);
    return q;
  endfunction

  function automatic logic [7:0] slot_of_value(logic [31:0] key);
    logic [7:0] i;
    int g;
    i = nxt_mdl[HEAD_SLOT];
    g = 0;
    while (i != 0 && elem_mdl[i] != key && g < 256) begin
      i = nxt_mdl[i];
      g++;
    end
    return (g < 256) ? i : 8'd0;
  endfunction

  // Applies one request to the list model and returns the result it yields.
  function automatic rsp_t apply_list_op(req_t r);
    logic st;
    logic [31:0] vo;
    logic [7:0] fs, k, j, i, fr, tl;
    int g;
    st = STATUS_ERR;
    vo = '0;
    fs = '0;
    case (r.action)
      ACT_INSERT: begin
        fr = nxt_mdl[FREE_SLOT];
        if (r.position >= 1 && r.position <= count_mdl + 1 && fr != 0) begin
          k = HEAD_SLOT;
          for (g = 0; g < r.position - 1; g++) k = nxt_mdl[k];
          nxt_mdl[FREE_SLOT] = nxt_mdl[fr];
          elem_mdl[fr] = r.value;
          nxt_mdl[fr] = nxt_mdl[k];
          nxt_mdl[k] = fr;
          count_mdl++;
          st = STATUS_OK;
        end
      end
      ACT_DELETE: begin
        if (r.position >= 1 && r.position <= count_mdl) begin
          k = HEAD_SLOT;
          for (g = 0; g < r.position - 1; g++) k = nxt_mdl[k];
          j = nxt_mdl[k];
          nxt_mdl[k] = nxt_mdl[j];
          vo = elem_mdl[j];
          nxt_mdl[j] = nxt_mdl[FREE_SLOT];
          nxt_mdl[FREE_SLOT] = j;
          count_mdl--;
          st = STATUS_OK;
        end
      end
      ACT_GET: begin
        if (r.position >= 1 && r.position <= count_mdl) begin
          k = HEAD_SLOT;
          for (g = 0; g < r.position; g++) k = nxt_mdl[k];
          vo = elem_mdl[k];
          st = STATUS_OK;
        end
      end
      ACT_LOCATE: begin
        fs = slot_of_value(r.value);
        st = (fs != 0) ? STATUS_OK : STATUS_ERR;
      end
      ACT_PRED: begin
        j = nxt_mdl[HEAD_SLOT];
        if (j != 0) begin
          i = nxt_mdl[j];
          g = 0;
          while (i != 0 && elem_mdl[i] != r.value && g < 256) begin
            j = i;
            i = nxt_mdl[i];
            g++;
          end
          if (i != 0 && g < 256) begin
            vo = elem_mdl[j];
            st = STATUS_OK;
          end
        end
      end
      ACT_SUCC: begin
        i = slot_of_value(r.value);
        if (i != 0 && nxt_mdl[i] != 0) begin
          vo = elem_mdl[nxt_mdl[i]];
          st = STATUS_OK;
        end
      end
      ACT_CLEAR: begin
        fr = nxt_mdl[HEAD_SLOT];
        if (fr != 0) begin
          tl = fr;
          g = 0;
          while (nxt_mdl[tl] != 0 && g < 256) begin
            tl = nxt_mdl[tl];
            g++;
          end
          nxt_mdl[tl] = nxt_mdl[FREE_SLOT];
          nxt_mdl[FREE_SLOT] = fr;
          nxt_mdl[HEAD_SLOT] = '0;
        end
        count_mdl = 0;
        st = STATUS_OK;
      end
      default: ;
    endcase
    return mk_rsp(st, vo, fs, count_mdl[7:0]);
  endfunction

  function automatic req_t mk_req(logic [2:0] a, logic [7:0] p, logic [31:0] v);
    req_t r;
    r.action = a;
    r.position = p;
    r.value = v;
    return r;
  endfunction

  // Random request: mostly valid positions and values already on the list.
  function automatic req_t pick_random_req(bit fill_bias);
    req_t r;
    int roll;
    logic [7:0] s;
    roll = $urandom_range(99);
    r.action = (roll < (fill_bias ? 60 : 30)) ? ACT_INSERT :
               (roll < 45) ? ACT_DELETE : (roll < 98) ? 3'($urandom_range(2, 5)) :
               (roll < 99) ? ACT_CLEAR : 3'd7;
    if ($urandom_range(9) == 0) r.position = 8'($urandom);
    else r.position = 8'($urandom_range(1, count_mdl + 1));
    r.value = $urandom;
    if (count_mdl > 0 && $urandom_range(3) != 0) begin
      s = HEAD_SLOT;
      for (int g = 0; g < $urandom_range(1, count_mdl); g++) s = nxt_mdl[s];
      r.value = elem_mdl[s];
    end else if ($urandom_range(3) == 0) begin
      r.value = 32'($urandom_range(3));
    end
    return r;
  endfunction

  task automatic send_req(req_t r);
    in_valid_i <= 1'b1;
    in_data_i <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent_count++;
  endtask

  task automatic idle_gap();
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      in_data_i <= 'x ^ 'x;
      @(posedge clk_i);
    end
  endtask

  // Wait until the block has drained, with the valid line low.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_rsps.size() != 0) @(posedge clk_i);
  endtask

  // Expectations are queued at acceptance, in the same step as the edge.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      rsp_t p;
      p = apply_list_op(in_data_i);
      if (pending_fixed.size() != 0) begin
        if (pending_fixed[0].fixed && pending_fixed[0].e !== p) begin
          mismatches++;
          if (mismatches <= 10)
            $display("table row disagrees with prediction: %p vs %p", pending_fixed[0].e, p);
        end
        void'(pending_fixed.pop_front());
      end
      expected_rsps.push_back(p);
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_rsps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data_o);
      end else begin
        rsp_t e;
        e = expected_rsps.pop_front();
        if (out_data_o.status !== e.status || out_data_o.value_out !== e.value_out ||
            out_data_o.slot_found !== e.slot_found ||
            out_data_o.list_length !== e.list_length ||
            out_data_o.is_empty !== e.is_empty) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected %p actual %p", e, out_data_o);
        end
      end
    end
  end

  // Receiver stall, with a long hold-off on request.
  always @(posedge clk_i) begin
    if (!rst_ni) out_stall_i <= 1'b1;
    else if (recv_hold) out_stall_i <= 1'b1;
    else out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        recv_hold = 1'b1;
        hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        if (hold == 0) recv_hold = 1'b0;
      end
    end
  end

  // Cycle limit.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int n;
    for (int i = 0; i < 256; i++) begin
      nxt_mdl[i] = (i + 2 < 256) ? 8'(i + 1) : 8'd0;
      elem_mdl[i] = '0;
    end
    count_mdl = 0;

    dir_tab[0]  = '{mk_req(ACT_GET, 8'd1, 32'd0), 1, mk_rsp(STATUS_ERR, 0, 0, 0)};
    dir_tab[1]  = '{mk_req(ACT_PRED, 8'd0, 32'd5), 1, mk_rsp(STATUS_ERR, 0, 0, 0)};
    dir_tab[2]  = '{mk_req(ACT_CLEAR, 8'd0, 32'd0), 1, mk_rsp(STATUS_OK, 0, 0, 0)};
    dir_tab[3]  = '{mk_req(ACT_INSERT, 8'd0, 32'd1), 1, mk_rsp(STATUS_ERR, 0, 0, 0)};
    dir_tab[4]  = '{mk_req(ACT_INSERT, 8'd2, 32'd1), 1, mk_rsp(STATUS_ERR, 0, 0, 0)};
    dir_tab[5]  = '{mk_req(ACT_INSERT, 8'd1, 32'h7FFFFFFF), 1, mk_rsp(STATUS_OK, 0, 0, 1)};
    dir_tab[6]  = '{mk_req(ACT_INSERT, 8'd1, 32'h80000000), 1, mk_rsp(STATUS_OK, 0, 0, 2)};
    dir_tab[7]  = '{mk_req(ACT_INSERT, 8'd3, 32'hFFFFFFFF), 1, mk_rsp(STATUS_OK, 0, 0, 3)};
    dir_tab[8]  = '{mk_req(ACT_GET, 8'd1, 32'd0), 1, mk_rsp(STATUS_OK, 32'h80000000, 0, 3)};
    dir_tab[9]  = '{mk_req(ACT_GET, 8'd255, 32'd0), 1, mk_rsp(STATUS_ERR, 0, 0, 3)};
    dir_tab[10] = '{mk_req(ACT_LOCATE, 8'd0, 32'h7FFFFFFF), 0, '0};
    dir_tab[11] = '{mk_req(ACT_LOCATE, 8'd0, 32'd42), 1, mk_rsp(STATUS_ERR, 0, 0, 3)};
    dir_tab[12] = '{mk_req(ACT_PRED, 8'd0, 32'h80000000), 1, mk_rsp(STATUS_ERR, 0, 0, 3)};
    dir_tab[13] = '{mk_req(ACT_PRED, 8'd0, 32'hFFFFFFFF), 0, '0};
    dir_tab[14] = '{mk_req(ACT_SUCC, 8'd0, 32'hFFFFFFFF), 1, mk_rsp(STATUS_ERR, 0, 0, 3)};
    dir_tab[15] = '{mk_req(ACT_SUCC, 8'd0, 32'h80000000), 0, '0};
    dir_tab[16] = '{mk_req(3'd7, 8'd1, 32'd0), 1, mk_rsp(STATUS_ERR, 0, 0, 3)};
    dir_tab[17] = '{mk_req(ACT_DELETE, 8'd0, 32'd0), 1, mk_rsp(STATUS_ERR, 0, 0, 3)};
    dir_tab[18] = '{mk_req(ACT_DELETE, 8'd4, 32'd0), 1, mk_rsp(STATUS_ERR, 0, 0, 3)};
    dir_tab[19] = '{mk_req(ACT_DELETE, 8'd2, 32'd0), 0, '0};
    dir_tab[20] = '{mk_req(ACT_INSERT, 8'd1, 32'd9), 0, '0};
    dir_tab[21] = '{mk_req(ACT_CLEAR, 8'd0, 32'd0), 1, mk_rsp(STATUS_OK, 0, 0, 0)};

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    recv_idle_pct = 30;

    for (int i = 0; i < DIRECTED_N; i++) begin
      pending_fixed.push_back(dir_tab[i]);
      send_req(dir_tab[i].r);
    end

    // Fill the list to capacity and try two more, so list full is reached.
    for (int i = 0; i < 256; i++) send_req(mk_req(ACT_INSERT, 8'($urandom_range(1, i + 1)),
                                                  $urandom));
    send_req(mk_req(ACT_GET, 8'd254, 32'd0));
    drain();

    // Long receiver hold-off while the sender keeps offering requests.
    hold_request = 1'b1;
    for (int i = 0; i < 40; i++) send_req(pick_random_req(0));
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 19 : (ph == 1) ? 81 : 0;
      recv_idle_pct = (ph == 0) ? 81 : (ph == 1) ? 19 : 0;
      n = (ph == 1) ? RANDOM_N / 4 : RANDOM_N * 3 / 8;
      for (int i = 0; i < n; i++) begin
        idle_gap();
        send_req(pick_random_req(count_mdl < 20));
      end
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: static_linked_list_manager_core.f
rtl/sllm_pkg.sv
rtl/sllm_datapath.sv
rtl/sllm_ctrl.sv
rtl/static_linked_list_manager_core.sv
rtl/sllm_checker.sv
verif/tb_static_linked_list_manager_core.sv
